FILE: rtl/core/lru_key_value_cache_assert.svh
// Assertion macros for the cache port checker.
// Each expects signals clk and rst in scope.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache port check failed");

// Next-cycle implication, disabled during reset.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache port sequence check failed");

`endif

FILE: rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared sizes, action and operation codes, request and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int CAP_W       = CNT_W;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ACT_W       = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REGIDX_W    = PADDR_W - 2;

  localparam logic [ACT_W-1:0] ACT_GET    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUT    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PROBE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 3'd4;

  localparam logic [REGIDX_W-1:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(ENTRIES);

  typedef enum logic [2:0] {
    OP_GET,
    OP_PUT,
    OP_REMOVE,
    OP_PROBE,
    OP_FLUSH,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cmd_t;

endpackage

FILE: rtl/core/lkvc_front.sv
// ----------------------------------------------------------------------------
// LRU key-value cache front end
// Accepts requests, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lkvc_pkg::req_t request,
  output lkvc_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import lkvc_pkg::*;

  entry_t            queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;
  op_t               op_dec;

  always_comb begin
    case (request.action)
      ACT_GET:    op_dec = OP_GET;
      ACT_PUT:    op_dec = OP_PUT;
      ACT_REMOVE: op_dec = OP_REMOVE;
      ACT_PROBE:  op_dec = OP_PROBE;
      ACT_FLUSH:  op_dec = OP_FLUSH;
      default:    op_dec = OP_NOP;
    endcase
  end

  assign busy      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign push      = start & ~busy;
  assign cmd.valid = (fill != '0);
  assign cmd.entry = queue[rd_ptr];
  assign pop       = cmd_pop & cmd.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= QCNT_W'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= QCNT_W'(fill - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: op_dec, key: request.lookup_key, value: request.write_value};
    end
  end

endmodule

FILE: rtl/core/lkvc_back.sv
// ----------------------------------------------------------------------------
// LRU key-value cache back end
// Looks up the queued request against all entries, then applies the
// recency and store update and issues the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lkvc_pkg::CAP_W-1:0]   capacity,
  input  lkvc_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         done,
  output lkvc_pkg::rsp_t               result
);
  import lkvc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t state;

  logic [KEY_W-1:0]   key_mem  [ENTRIES];
  logic [VAL_W-1:0]   val_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   rank     [ENTRIES];
  logic [CNT_W-1:0]   count;

  // lookup
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lru_oh;
  logic [ENTRIES-1:0] valid_after_evict;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   lru_idx;
  logic [CNT_W-1:0]   count_m1;
  logic [CAP_W-1:0]   cap_eff;
  logic               evict;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               free_ev_found;
  logic [IDX_W-1:0]   free_ev_idx;

  // lookup registers
  op_t              l_op;
  logic             l_hit;
  logic [IDX_W-1:0] l_hit_idx;
  logic [IDX_W-1:0] l_lru_idx;
  logic             l_evict;
  logic             l_ins_found;
  logic [IDX_W-1:0] l_ins_idx;
  logic [KEY_W-1:0] l_key;
  logic [VAL_W-1:0] l_value;

  // apply
  logic [ENTRIES-1:0] valid_next;
  logic [IDX_W-1:0]   rank_next [ENTRIES];
  logic [CNT_W-1:0]   count_next;
  logic [IDX_W-1:0]   hit_rank;
  logic               key_we;
  logic               val_we;
  logic [IDX_W-1:0]   wr_idx;
  logic               take;

  assign cmd_pop = (state == S_IDLE);
  assign take    = cmd_pop & cmd.valid;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_W'(ENTRIES)) begin
      cap_eff = CAP_W'(ENTRIES);
    end else begin
      cap_eff = capacity;
    end
  end

  assign count_m1 = CNT_W'(count - 1'b1);

  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (key_mem[i] == cmd.entry.key);
      lru_oh[i] = valid[i] && (CNT_W'(rank[i]) == count_m1);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (lru_oh[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
  end

  assign hit_any = |match;
  assign evict   = (cmd.entry.op == OP_PUT) && !hit_any && (count != '0)
                   && (count >= CNT_W'(cap_eff));
  assign valid_after_evict = valid & ~lru_oh;

  always_comb begin
    free_found    = 1'b0;
    free_idx      = '0;
    free_ev_found = 1'b0;
    free_ev_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (!valid_after_evict[i]) begin
        free_ev_found = 1'b1;
        free_ev_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      l_op        <= cmd.entry.op;
      l_hit       <= hit_any && (cmd.entry.op inside {OP_GET, OP_PUT, OP_REMOVE, OP_PROBE});
      l_hit_idx   <= hit_idx;
      l_lru_idx   <= lru_idx;
      l_evict     <= evict;
      l_ins_found <= evict ? free_ev_found : free_found;
      l_ins_idx   <= evict ? free_ev_idx : free_idx;
      l_key       <= cmd.entry.key;
      l_value     <= cmd.entry.value;
    end
  end

  assign hit_rank = rank[l_hit_idx];

  always_comb begin
    valid_next = valid;
    rank_next  = rank;
    count_next = count;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_idx     = l_hit_idx;
    case (l_op)
      OP_GET, OP_PUT: begin
        if (l_hit) begin
          val_we = (l_op == OP_PUT);
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && (rank[i] < hit_rank)) begin
              rank_next[i] = IDX_W'(rank[i] + 1'b1);
            end
          end
          rank_next[l_hit_idx] = '0;
        end else if (l_op == OP_PUT) begin
          if (l_evict) begin
            valid_next[l_lru_idx] = 1'b0;
            rank_next[l_lru_idx]  = '0;
            count_next            = CNT_W'(count - 1'b1);
          end
          if (l_ins_found) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_next[i]) begin
                rank_next[i] = IDX_W'(rank_next[i] + 1'b1);
              end
            end
            key_we                = 1'b1;
            val_we                = 1'b1;
            wr_idx                = l_ins_idx;
            valid_next[l_ins_idx] = 1'b1;
            rank_next[l_ins_idx]  = '0;
            count_next            = CNT_W'(count_next + 1'b1);
          end
        end
      end
      OP_REMOVE: begin
        if (l_hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && (rank[i] > hit_rank)) begin
              rank_next[i] = IDX_W'(rank[i] - 1'b1);
            end
          end
          valid_next[l_hit_idx] = 1'b0;
          rank_next[l_hit_idx]  = '0;
          count_next            = CNT_W'(count - 1'b1);
        end
      end
      OP_FLUSH: begin
        valid_next = '0;
        rank_next  = '{default: '0};
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (cmd.valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          done                 <= 1'b1;
          result.hit           <= l_hit;
          result.read_value    <= (l_op == OP_GET && l_hit) ? val_mem[l_hit_idx] : '0;
          result.evicted       <= l_evict;
          result.evicted_key   <= l_evict ? key_mem[l_lru_idx] : '0;
          result.entry_count   <= count_next;
          state                <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rank  <= '{default: '0};
      count <= '0;
    end else if (state == S_APPLY) begin
      valid <= valid_next;
      rank  <= rank_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      if (key_we) begin
        key_mem[wr_idx] <= l_key;
      end
      if (val_we) begin
        val_mem[wr_idx] <= l_value;
      end
    end
  end

endmodule

FILE: rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/request; one is taken at each clock edge where
//   start is high and busy is low. Actions: get, put, remove, probe, flush.
//   Each request yields exactly one result on the result port, marked by done
//   for one cycle; the receiver must take it then.
//   A taken request passes the queue, the lookup registers and the result
//   registers before done rises. The back end takes a new request only after
//   applying the last one, as it looks up and then updates the entry registers.
//   A two-deep request queue sits between front and back; busy rises when it
//   is full.
//   The capacity register sits at byte address 0 of the APB port. Write it only
//   while idle and while the store is empty.
//   Reset empties the store, clears the queue and sets capacity to the entry
//   count. No result is lost, since the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lkvc_pkg::req_t                 request,
  output logic                           done,
  output lkvc_pkg::rsp_t                 result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::PDATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0]    capacity;
  logic [REGIDX_W-1:0] reg_idx;
  logic                reg_wr;
  cmd_t                cmd;
  logic                cmd_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (reg_wr && (reg_idx == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  lkvc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  lkvc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .done     (done),
    .result   (result)
  );

endmodule

FILE: rtl/core/lkvc_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache port checker
// Watches the result port of the cache for illegal combinations over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lru_key_value_cache_assert.svh"

module lkvc_checker (
  input logic           clk,
  input logic           rst,
  input logic           done,
  input lkvc_pkg::rsp_t result
);
  import lkvc_pkg::*;

  `LKVC_ASSERT_NEXT(a_done_spacing, done, !done)
  `LKVC_ASSERT_NOW(a_count_bound, done, result.entry_count <= CNT_W'(ENTRIES))
  `LKVC_ASSERT_NOW(a_miss_no_data, done && !result.hit, result.read_value == '0)
  `LKVC_ASSERT_NOW(a_evict_on_miss, done && result.evicted, !result.hit)
  `LKVC_ASSERT_NOW(a_no_evict_key, done && !result.evicted, result.evicted_key == '0)

endmodule

bind lru_key_value_cache lkvc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);

FILE: verif/lru_key_value_cache_test.sv
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get, put, remove, probe, flush and spare actions through the command
// port, with random gaps in most phases, and keeps a shadow copy of the store
// with its recency ranks. Every result is checked against that copy in order.
// The capacity register is rewritten over APB between phases once the cache
// is idle, covering zero, one, full size, oversized values and lowering it
// below the current entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam logic [ACT_W-1:0]   ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0]   ACT_SPARE_HI  = 3'd7;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam int                 CAP_MAX_WORD  = (1 << CAP_W) - 1;
  localparam int                 CYCLE_LIMIT   = 400000;
  localparam int                 DRAIN_CYCLES  = 8;
  localparam int                 PHASES        = 10;
  localparam int                 PHASE_ITEMS   = 140;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  logic               busy;
  req_t               request = '0;
  logic               done;
  rsp_t               result;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  req_t        req_backlog[$];
  rsp_t        predicted_rsps[$];
  bit          gaps_on     = 1'b1;
  int unsigned gap_left    = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  logic [KEY_W-1:0] key_mem[ENTRIES];
  logic [VAL_W-1:0] val_mem[ENTRIES];
  bit               live[ENTRIES];
  int               age[ENTRIES];
  int               live_count;
  logic [CAP_W-1:0] capacity_reg;
  logic [KEY_W-1:0] key_pool[$];

  lru_key_value_cache uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // make an entry the most recent, aging the ones that were newer
  task automatic promote(input int idx);
    int r;
    r = age[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && age[i] < r) age[i]++;
    age[idx] = 0;
  endtask

  // invalidate an entry and close the gap in the ranks
  task automatic retire(input int idx);
    int r;
    r = age[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && age[i] > r) age[i]--;
    live[idx] = 1'b0;
    age[idx]  = 0;
    if (live_count > 0) live_count--;
  endtask

  task automatic apply_request(input req_t rq);
    rsp_t rs;
    int   slot;
    int   oldest;
    int   limit;
    rs   = '0;
    slot = -1;
    if (rq.action <= ACT_PROBE) begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && live[i] && key_mem[i] == rq.lookup_key) slot = i;
      rs.hit = (slot >= 0);
      if (rq.action == ACT_GET && slot >= 0) begin
        rs.read_value = val_mem[slot];
        promote(slot);
      end else if (rq.action == ACT_PUT) begin
        if (slot >= 0) begin
          val_mem[slot] = rq.write_value;
          promote(slot);
        end else begin
          limit = (capacity_reg == 0) ? 1 :
                  (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
          if (live_count >= limit) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (live[i] && (oldest < 0 || age[i] > age[oldest])) oldest = i;
            if (oldest >= 0) begin
              rs.evicted     = 1'b1;
              rs.evicted_key = key_mem[oldest];
              retire(oldest);
            end
          end
          slot = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !live[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (live[i]) age[i]++;
            key_mem[slot] = rq.lookup_key;
            val_mem[slot] = rq.write_value;
            live[slot]    = 1'b1;
            age[slot]     = 0;
            live_count++;
          end
        end
      end else if (rq.action == ACT_REMOVE && slot >= 0) begin
        retire(slot);
      end
    end else if (rq.action == ACT_FLUSH) begin
      for (int i = 0; i < ENTRIES; i++) begin
        live[i] = 1'b0;
        age[i]  = 0;
      end
      live_count = 0;
    end
    rs.entry_count = CNT_W'(live_count);
    predicted_rsps.push_back(rs);
  endtask

  always @(posedge clk) begin : drive_requests
    bit holding;
    holding = start;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        apply_request(request);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          request  <= req_backlog.pop_front();
          start    <= 1'b1;
          gap_left <= gaps_on ? $urandom_range(0, 6) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (predicted_rsps.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: hit=%b read_value=%h evicted=%b evicted_key=%h count=%0d",
                   result.hit, result.read_value, result.evicted, result.evicted_key,
                   result.entry_count);
        fail_count++;
      end else begin
        want = predicted_rsps.pop_front();
        if (result.hit !== want.hit || result.read_value !== want.read_value ||
            result.evicted !== want.evicted || result.evicted_key !== want.evicted_key ||
            result.entry_count !== want.entry_count) begin
          if (fail_count < 10)
            $display("exp hit=%b rd=%h ev=%b evk=%h cnt=%0d, got hit=%b rd=%h ev=%b evk=%h cnt=%0d",
                     want.hit, want.read_value, want.evicted, want.evicted_key,
                     want.entry_count, result.hit, result.read_value, result.evicted,
                     result.evicted_key, result.entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    req_t rq;
    rq.action      = act;
    rq.lookup_key  = key;
    rq.write_value = value;
    req_backlog.push_back(rq);
  endtask

  // hold until every request is taken and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || start || predicted_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [PDATA_W-1:0] word);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    capacity_reg = word[CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [PDATA_W-1:0] cap_word;
    logic [ACT_W-1:0]   act;
    logic [KEY_W-1:0]   key;
    int unsigned        roll;
    int                 pool_size;
    for (int i = 0; i < ENTRIES; i++) begin
      live[i] = 1'b0;
      age[i]  = 0;
    end
    live_count   = 0;
    capacity_reg = CAP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // basic actions at reset capacity
    push_req(ACT_GET, '0, '0);
    push_req(ACT_PUT, '0, '1);
    push_req(ACT_PUT, '1, '0);
    push_req(ACT_PUT, 32'h5A5A_A5A5, 32'h1234_5678);
    push_req(ACT_GET, '1, '1);
    push_req(ACT_GET, '0, '0);
    push_req(ACT_PROBE, 32'h5A5A_A5A5, '1);
    push_req(ACT_PROBE, 32'h0000_0001, '0);
    push_req(ACT_PUT, '0, 32'hCAFE_F00D);
    push_req(ACT_GET, '0, '0);
    push_req(ACT_REMOVE, '1, '0);
    push_req(ACT_REMOVE, '1, '0);
    push_req(ACT_SPARE_LO, '0, '1);
    push_req(ACT_SPARE_LO + 3'd1, '1, '0);
    push_req(ACT_SPARE_HI, 32'h5A5A_A5A5, '1);
    push_req(ACT_FLUSH, '1, '1);
    push_req(ACT_GET, '0, '0);
    wait_drained();

    // single entry: each new key displaces the previous one
    write_capacity(32'd1);
    push_req(ACT_PUT, 32'h0000_0011, 32'hAAAA_0001);
    push_req(ACT_PUT, 32'h0000_0022, 32'hAAAA_0002);
    push_req(ACT_GET, 32'h0000_0011, '0);
    push_req(ACT_GET, 32'h0000_0022, '0);
    wait_drained();

    // zero capacity behaves as one
    write_capacity(32'd0);
    push_req(ACT_PUT, 32'h8000_0000, 32'hBBBB_0001);
    push_req(ACT_PUT, 32'h7FFF_FFFF, 32'hBBBB_0002);
    wait_drained();

    // oversized capacity with junk in the upper bits
    write_capacity('1);
    push_req(ACT_PUT, 32'h0000_0033, 32'hCCCC_0001);
    push_req(ACT_PUT, 32'h0000_0044, 32'hCCCC_0002);
    wait_drained();

    // capacity lowered below the entry count
    write_capacity(32'd2);
    push_req(ACT_PUT, 32'h0000_0055, 32'hDDDD_0001);
    push_req(ACT_GET, 32'h0000_0055, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase == 0) begin
        cap_word = ENTRIES;
      end else if (phase == 1) begin
        cap_word = 1;
      end else begin
        case ($urandom_range(0, 9))
          0:       cap_word = 0;
          1:       cap_word = $urandom_range(ENTRIES + 1, CAP_MAX_WORD);
          default: cap_word = $urandom_range(1, ENTRIES);
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        cap_word[PDATA_W-1:CAP_W] = (PDATA_W - CAP_W)'($urandom);
      write_capacity(cap_word);
      gaps_on = (phase % 3 != 2);
      key_pool.delete();
      pool_size = $urandom_range(2, 24);
      repeat (pool_size) key_pool.push_back(pick_word());
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      act = ACT_GET;
        else if (roll < 72) act = ACT_PUT;
        else if (roll < 84) act = ACT_REMOVE;
        else if (roll < 95) act = ACT_PROBE;
        else if (roll < 98) act = ACT_FLUSH;
        else                act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        push_req(act, key, pick_word());
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
